>>> hw/rtl/obspt_pkg.sv
// Shared codes, widths and control types for the order book side.
package obspt_pkg;

    localparam int PRICE_W = 32;
    localparam int ID_W    = 32;
    localparam int QTY_W   = 32;
    localparam int TOTAL_W = 36;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [2:0] CMD_NOP        = 3'd0;
    localparam logic [2:0] CMD_LOAD       = 3'd1;
    localparam logic [2:0] CMD_APPEND     = 3'd2;
    localparam logic [2:0] CMD_DROP       = 3'd3;
    localparam logic [2:0] CMD_ROT        = 3'd4;
    localparam logic [2:0] CMD_FROM_LEFT  = 3'd5;
    localparam logic [2:0] CMD_FROM_RIGHT = 3'd6;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
        logic full;
        logic front_match;
    } cell_stat_t;

endpackage

>>> hw/rtl/obspt_cell.sv
// One price level cell: price, running total and a shift queue of orders.
module obspt_cell
    import obspt_pkg::*;
#(
    parameter int OPL = 16,
    parameter int CW  = 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctl_t                    ctl,
    input  logic [PRICE_W-1:0]           left_price,
    input  logic [TOTAL_W-1:0]           left_total,
    input  logic [CW-1:0]                left_count,
    input  logic [OPL-1:0][ID_W-1:0]     left_ids,
    input  logic [OPL-1:0][QTY_W-1:0]    left_qtys,
    input  logic [PRICE_W-1:0]           right_price,
    input  logic [TOTAL_W-1:0]           right_total,
    input  logic [CW-1:0]                right_count,
    input  logic [OPL-1:0][ID_W-1:0]     right_ids,
    input  logic [OPL-1:0][QTY_W-1:0]    right_qtys,
    output logic [PRICE_W-1:0]           price,
    output logic [TOTAL_W-1:0]           total,
    output logic [CW-1:0]                count,
    output logic [OPL-1:0][ID_W-1:0]     ids,
    output logic [OPL-1:0][QTY_W-1:0]    qtys,
    output cell_stat_t                   stat
);

    logic [PRICE_W-1:0]        price_reg, price_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [OPL-1:0][ID_W-1:0]  ids_reg, ids_next;
    logic [OPL-1:0][QTY_W-1:0] qtys_reg, qtys_next;
    logic                      valid;
    logic                      hit_front;

    assign valid     = (count_reg != '0);
    assign hit_front = (ids_reg[0] == ctl.id);

    assign stat.valid       = valid;
    assign stat.lt          = valid && (price_reg < ctl.price);
    assign stat.eq          = valid && (price_reg == ctl.price);
    assign stat.full        = (count_reg == CW'(OPL));
    assign stat.front_match = valid && hit_front;

    assign price = price_reg;
    assign total = total_reg;
    assign count = count_reg;
    assign ids   = ids_reg;
    assign qtys  = qtys_reg;

    always_comb
    begin
        price_next = price_reg;
        total_next = total_reg;
        count_next = count_reg;
        ids_next   = ids_reg;
        qtys_next  = qtys_reg;
        case (ctl.cmd)
            CMD_LOAD:
            begin
                price_next   = ctl.price;
                total_next   = {{(TOTAL_W-QTY_W){1'b0}}, ctl.qty};
                count_next   = CW'(1);
                ids_next[0]  = ctl.id;
                qtys_next[0] = ctl.qty;
            end
            CMD_APPEND:
            begin
                for (int j = 0; j < OPL; j++)
                begin
                    if (CW'(j) == count_reg)
                    begin
                        ids_next[j]  = ctl.id;
                        qtys_next[j] = ctl.qty;
                    end
                end
                count_next = count_reg + CW'(1);
                total_next = total_reg + {{(TOTAL_W-QTY_W){1'b0}}, ctl.qty};
            end
            CMD_DROP, CMD_ROT:
            begin
                for (int j = 0; j < OPL - 1; j++)
                begin
                    ids_next[j]  = ids_reg[j+1];
                    qtys_next[j] = qtys_reg[j+1];
                end
                if (ctl.cmd == CMD_DROP || hit_front)
                begin
                    count_next = count_reg - CW'(1);
                    total_next = total_reg - {{(TOTAL_W-QTY_W){1'b0}}, qtys_reg[0]};
                end
                else
                begin
                    for (int j = 0; j < OPL; j++)
                    begin
                        if (CW'(j + 1) == count_reg)
                        begin
                            ids_next[j]  = ids_reg[0];
                            qtys_next[j] = qtys_reg[0];
                        end
                    end
                end
            end
            CMD_FROM_LEFT:
            begin
                price_next = left_price;
                total_next = left_total;
                count_next = left_count;
                ids_next   = left_ids;
                qtys_next  = left_qtys;
            end
            CMD_FROM_RIGHT:
            begin
                price_next = right_price;
                total_next = right_total;
                count_next = right_count;
                ids_next   = right_ids;
                qtys_next  = right_qtys;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        total_reg <= total_next;
        ids_reg   <= ids_next;
        qtys_reg  <= qtys_next;
    end

endmodule

>>> hw/rtl/order_book_side_price_time.sv
// Every op passes S_EXEC and S_REPORT; result_valid strobes after S_REPORT. An ask-side
// remove that deletes its level adds S_DEL. Cancel at an absent price goes to S_REPORT; else
// it rotates the level in S_SCAN, one rotation a cycle, once per order, then S_SCANEND and
// S_DEL if the level empties. One op at a time; busy drops as the result beat shows.
// Inserting or deleting a level shifts the cells from that level on one place along the chain.
// Reset: asynchronous, active low; empty book, side bit 0 (ask); the receiver cannot stall.
module order_book_side_price_time
    import obspt_pkg::*;
#(
    parameter int MAX_LEVELS       = 64,
    parameter int ORDERS_PER_LEVEL = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [ID_W-1:0]     order_ref,
    input  logic [PRICE_W-1:0]  order_price,
    input  logic [QTY_W-1:0]    order_qty,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    output logic                result_valid,
    output logic [1:0]          status,
    output logic                book_empty,
    output logic [PRICE_W-1:0]  best_price,
    output logic [ID_W-1:0]     best_id,
    output logic [QTY_W-1:0]    best_qty,
    output logic [TOTAL_W-1:0]  best_level_total
);

    localparam int L   = MAX_LEVELS;
    localparam int OPL = ORDERS_PER_LEVEL;
    localparam int CW  = $clog2(OPL + 1);
    localparam int UW  = $clog2(L + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_SCANEND = 3'd3;
    localparam logic [2:0] S_DEL     = 3'd4;
    localparam logic [2:0] S_REPORT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               side_reg;
    logic [1:0]         op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [UW-1:0]      used_reg, used_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               hit_reg, hit_next;
    logic               del_all_reg, del_all_next;
    logic [1:0]         status_reg, status_next;
    logic               strobe_reg;

    logic [PRICE_W-1:0]        c_price [L];
    logic [TOTAL_W-1:0]        c_total [L];
    logic [CW-1:0]             c_count [L];
    logic [OPL-1:0][ID_W-1:0]  c_ids   [L];
    logic [OPL-1:0][QTY_W-1:0] c_qtys  [L];
    cell_stat_t                c_stat  [L];
    cell_ctl_t                 c_ctl   [L];
    logic [L-1:0]              best_oh;

    logic                do_insert, do_append, do_pop, do_rot, do_del;
    logic                eq_any, full_any, match_any;
    logic [CW-1:0]       eq_count;
    logic [CW-1:0]       best_count;
    logic [PRICE_W-1:0]  sel_price;
    logic [ID_W-1:0]     sel_id;
    logic [QTY_W-1:0]    sel_qty;
    logic [TOTAL_W-1:0]  sel_total;

    logic [PRICE_W-1:0]  out_price_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [QTY_W-1:0]    out_qty_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_empty_reg;
    logic [1:0]          out_status_reg;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    genvar g;
    generate
        for (g = 0; g < L; g++)
        begin : g_cell
            logic [PRICE_W-1:0]        lp, rp;
            logic [TOTAL_W-1:0]        lt_tot, rt_tot;
            logic [CW-1:0]             lc, rc;
            logic [OPL-1:0][ID_W-1:0]  li, ri;
            logic [OPL-1:0][QTY_W-1:0] lq, rq;
            logic                      ins;

            if (g == 0)
            begin : g_first
                assign lp     = '0;
                assign lt_tot = '0;
                assign lc     = '0;
                assign li     = '0;
                assign lq     = '0;
                assign ins    = !c_stat[g].lt;
            end
            else
            begin : g_mid
                assign lp     = c_price[g-1];
                assign lt_tot = c_total[g-1];
                assign lc     = c_count[g-1];
                assign li     = c_ids[g-1];
                assign lq     = c_qtys[g-1];
                assign ins    = !c_stat[g].lt && c_stat[g-1].lt;
            end

            if (g == L - 1)
            begin : g_last
                assign rp     = '0;
                assign rt_tot = '0;
                assign rc     = '0;
                assign ri     = '0;
                assign rq     = '0;
                assign best_oh[g] = side_reg ? c_stat[g].valid : (g == 0);
            end
            else
            begin : g_inner
                assign rp     = c_price[g+1];
                assign rt_tot = c_total[g+1];
                assign rc     = c_count[g+1];
                assign ri     = c_ids[g+1];
                assign rq     = c_qtys[g+1];
                assign best_oh[g] = side_reg ? (c_stat[g].valid && !c_stat[g+1].valid)
                                             : (g == 0);
            end

            always_comb
            begin
                c_ctl[g].id    = id_reg;
                c_ctl[g].price = price_reg;
                c_ctl[g].qty   = qty_reg;
                if (do_insert)
                    c_ctl[g].cmd = ins ? CMD_LOAD : (!c_stat[g].lt ? CMD_FROM_LEFT : CMD_NOP);
                else if (do_append && c_stat[g].eq)
                    c_ctl[g].cmd = CMD_APPEND;
                else if (do_pop && best_oh[g])
                    c_ctl[g].cmd = CMD_DROP;
                else if (do_rot && c_stat[g].eq)
                    c_ctl[g].cmd = CMD_ROT;
                else if (do_del && (del_all_reg || !c_stat[g].lt))
                    c_ctl[g].cmd = CMD_FROM_RIGHT;
                else
                    c_ctl[g].cmd = CMD_NOP;
            end

            obspt_cell #(
                .OPL (OPL),
                .CW  (CW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (c_ctl[g]),
                .left_price  (lp),
                .left_total  (lt_tot),
                .left_count  (lc),
                .left_ids    (li),
                .left_qtys   (lq),
                .right_price (rp),
                .right_total (rt_tot),
                .right_count (rc),
                .right_ids   (ri),
                .right_qtys  (rq),
                .price       (c_price[g]),
                .total       (c_total[g]),
                .count       (c_count[g]),
                .ids         (c_ids[g]),
                .qtys        (c_qtys[g]),
                .stat        (c_stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        eq_any     = 1'b0;
        full_any   = 1'b0;
        match_any  = 1'b0;
        eq_count   = '0;
        best_count = '0;
        sel_price  = '0;
        sel_id     = '0;
        sel_qty    = '0;
        sel_total  = '0;
        for (int i = 0; i < L; i++)
        begin
            eq_any    = eq_any | c_stat[i].eq;
            full_any  = full_any | (c_stat[i].eq & c_stat[i].full);
            match_any = match_any | (c_stat[i].eq & c_stat[i].front_match);
            eq_count  = eq_count | (c_stat[i].eq ? c_count[i] : '0);
            if (best_oh[i])
            begin
                best_count = best_count | c_count[i];
                sel_price  = sel_price | c_price[i];
                sel_id     = sel_id | c_ids[i][0];
                sel_qty    = sel_qty | c_qtys[i][0];
                sel_total  = sel_total | c_total[i];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        del_all_next = del_all_reg;
        status_next  = status_reg;
        do_insert    = 1'b0;
        do_append    = 1'b0;
        do_pop       = 1'b0;
        do_rot       = 1'b0;
        do_del       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                state_next  = S_REPORT;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (eq_any)
                        begin
                            if (full_any)
                                status_next = ST_FULL;
                            else
                                do_append = 1'b1;
                        end
                        else if (used_reg == UW'(L))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            do_insert = 1'b1;
                            used_next = used_reg + UW'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (used_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            do_pop = 1'b1;
                            if (best_count == CW'(1))
                            begin
                                if (side_reg)
                                begin
                                    used_next = used_reg - UW'(1);
                                end
                                else
                                begin
                                    del_all_next = 1'b1;
                                    state_next   = S_DEL;
                                end
                            end
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (!eq_any)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            scan_next  = eq_count;
                            hit_next   = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                do_rot    = 1'b1;
                hit_next  = hit_reg | match_any;
                scan_next = scan_reg - CW'(1);
                if (scan_reg == CW'(1))
                    state_next = S_SCANEND;
            end
            S_SCANEND:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_REPORT;
                end
                else if (!eq_any)
                begin
                    del_all_next = 1'b0;
                    state_next   = S_DEL;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_DEL:
            begin
                do_del     = 1'b1;
                used_next  = used_reg - UW'(1);
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            side_reg    <= 1'b0;
            used_reg    <= '0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            del_all_reg <= 1'b0;
            status_reg  <= ST_DONE;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            scan_reg    <= scan_next;
            hit_reg     <= hit_next;
            del_all_reg <= del_all_next;
            status_reg  <= status_next;
            strobe_reg  <= (state_reg == S_REPORT);
            if (cfg_valid)
                side_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg    <= op;
            id_reg    <= order_ref;
            price_reg <= order_price;
            qty_reg   <= order_qty;
        end
        if (state_reg == S_REPORT)
        begin
            out_status_reg <= status_reg;
            out_empty_reg  <= (used_reg == '0);
            out_price_reg  <= (used_reg == '0) ? '0 : sel_price;
            out_id_reg     <= (used_reg == '0) ? '0 : sel_id;
            out_qty_reg    <= (used_reg == '0) ? '0 : sel_qty;
            out_total_reg  <= (used_reg == '0) ? '0 : sel_total;
        end
    end

    assign result_valid     = strobe_reg;
    assign status           = out_status_reg;
    assign book_empty       = out_empty_reg;
    assign best_price       = out_price_reg;
    assign best_id          = out_id_reg;
    assign best_qty         = out_qty_reg;
    assign best_level_total = out_total_reg;

endmodule

>>> sim/order_book_side_price_time_tb.sv
// Self-checking testbench for the order book side with price-time priority.
`timescale 1ns / 1ps
module order_book_side_price_time_tb;
    import obspt_pkg::*;

    localparam int LEVELS = 64;
    localparam int DEPTH  = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } book_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               empty;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
        logic [TOTAL_W-1:0] total;
    } book_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = OP_QUERY;
    logic [ID_W-1:0] order_ref = '0;
    logic [PRICE_W-1:0] order_price = '0;
    logic [QTY_W-1:0] order_qty = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic result_valid;
    logic [1:0] status;
    logic book_empty;
    logic [PRICE_W-1:0] best_price;
    logic [ID_W-1:0] best_id;
    logic [QTY_W-1:0] best_qty;
    logic [TOTAL_W-1:0] best_level_total;

    order_book_side_price_time dut (.*);

    // shadow book
    logic               bid_side;
    logic [PRICE_W-1:0] lvl_price [LEVELS];
    logic [TOTAL_W-1:0] lvl_total [LEVELS];
    int                 lvl_count [LEVELS];
    logic [ID_W-1:0]    lvl_id    [LEVELS][DEPTH];
    logic [QTY_W-1:0]   lvl_qty   [LEVELS][DEPTH];
    int                 used;

    book_cmd_t  pending_cmds [$];
    book_view_t expected_views [$];
    book_cmd_t  beat;
    int  fails = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_for_drain = 1'b0;
    bit  drain_done = 1'b0;

    function automatic void move_level(int d, int s);
        lvl_price[d] = lvl_price[s];
        lvl_total[d] = lvl_total[s];
        lvl_count[d] = lvl_count[s];
        lvl_id[d] = lvl_id[s];
        lvl_qty[d] = lvl_qty[s];
    endfunction

    function automatic int find_pos(logic [PRICE_W-1:0] p);
        int i;
        i = 0;
        while (i < used && lvl_price[i] < p) i++;
        return i;
    endfunction

    function automatic void delete_level(int pos);
        for (int i = pos; i + 1 < used; i++) move_level(i, i + 1);
        used--;
        lvl_count[used] = 0;
    endfunction

    function automatic book_view_t apply_book_cmd(book_cmd_t c);
        book_view_t v;
        int pos, n, k, b;
        bit hit;
        v = '0;
        v.status = ST_DONE;
        case (c.op)
            OP_ADD:
            begin
                pos = find_pos(c.price);
                if (pos >= used || lvl_price[pos] != c.price) begin
                    if (used >= LEVELS) v.status = ST_FULL;
                    else begin
                        for (int i = used; i > pos; i--) move_level(i, i - 1);
                        lvl_price[pos] = c.price;
                        lvl_total[pos] = '0;
                        lvl_count[pos] = 0;
                        used++;
                    end
                end else if (lvl_count[pos] >= DEPTH) v.status = ST_FULL;
                if (v.status == ST_DONE) begin
                    n = lvl_count[pos];
                    lvl_id[pos][n] = c.id;
                    lvl_qty[pos][n] = c.qty;
                    lvl_count[pos] = n + 1;
                    lvl_total[pos] = lvl_total[pos] + TOTAL_W'(c.qty);
                end
            end
            OP_REMOVE:
            begin
                if (used == 0) v.status = ST_EMPTY;
                else begin
                    pos = bid_side ? used - 1 : 0;
                    n = lvl_count[pos];
                    if (n > 0) begin
                        lvl_total[pos] = lvl_total[pos] - TOTAL_W'(lvl_qty[pos][0]);
                        for (int i = 0; i + 1 < n; i++) begin
                            lvl_id[pos][i] = lvl_id[pos][i + 1];
                            lvl_qty[pos][i] = lvl_qty[pos][i + 1];
                        end
                        lvl_count[pos] = n - 1;
                    end
                    if (lvl_count[pos] == 0) delete_level(pos);
                end
            end
            OP_CANCEL:
            begin
                pos = find_pos(c.price);
                if (pos >= used || lvl_price[pos] != c.price) v.status = ST_NOT_FOUND;
                else begin
                    n = lvl_count[pos];
                    k = 0;
                    hit = 1'b0;
                    for (int i = 0; i < n; i++) begin
                        if (lvl_id[pos][i] == c.id) begin
                            lvl_total[pos] = lvl_total[pos] - TOTAL_W'(lvl_qty[pos][i]);
                            hit = 1'b1;
                        end else begin
                            lvl_id[pos][k] = lvl_id[pos][i];
                            lvl_qty[pos][k] = lvl_qty[pos][i];
                            k++;
                        end
                    end
                    lvl_count[pos] = k;
                    if (!hit) v.status = ST_NOT_FOUND;
                    else if (k == 0) delete_level(pos);
                end
            end
            default: ;
        endcase
        if (used == 0) v.empty = 1'b1;
        else begin
            b = bid_side ? used - 1 : 0;
            v.price = lvl_price[b];
            v.id = lvl_id[b][0];
            v.qty = lvl_qty[b][0];
            v.total = lvl_total[b];
        end
        return v;
    endfunction

    function automatic book_cmd_t make_cmd(logic [1:0] o, logic [31:0] i, logic [31:0] p,
                                           logic [31:0] q);
        book_cmd_t c;
        c.op = o;
        c.id = i;
        c.price = p;
        c.qty = q;
        return c;
    endfunction

    function automatic logic [31:0] rand_wide();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_views.push_back(apply_book_cmd(beat));
            end
            if (start && busy) begin
            end else if (hold_for_drain && !drain_done) begin
                start <= 1'b0;
            end else if (pending_cmds.size() > 0 && burst_left > 0) begin
                beat = pending_cmds.pop_front();
                start <= 1'b1;
                op <= beat.op;
                order_ref <= beat.id;
                order_price <= beat.price;
                order_qty <= beat.qty;
                burst_left <= burst_left - 1;
            end else begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
                else begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        book_view_t e;
        if (rst_n) begin
            idle_cycles <= (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                           ? 0 : idle_cycles + 1;
            if (result_valid) begin
                if (expected_views.size() == 0) begin
                    $error("result with nothing expected");
                    fails++;
                end else begin
                    e = expected_views.pop_front();
                    if (status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, status); fails++; end
                    if (book_empty !== e.empty) begin
                        $error("book_empty exp %0d got %0d", e.empty, book_empty); fails++; end
                    if (best_price !== e.price) begin
                        $error("best_price exp %0h got %0h", e.price, best_price); fails++; end
                    if (best_id !== e.id) begin
                        $error("best_id exp %0h got %0h", e.id, best_id); fails++; end
                    if (best_qty !== e.qty) begin
                        $error("best_qty exp %0h got %0h", e.qty, best_qty); fails++; end
                    if (best_level_total !== e.total) begin
                        $error("best_level_total exp %0h got %0h", e.total, best_level_total);
                        fails++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || busy || expected_views.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_side(logic s);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        bid_side = s;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int count, int price_span);
        logic [31:0] base;
        int r;
        base = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 : $urandom_range(100, 1000);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                pending_cmds.push_back(make_cmd(OP_ADD, $urandom_range(0, 7) == 0 ? rand_wide() :
                    $urandom_range(1, 20), base + $urandom_range(0, price_span),
                    rand_wide()));
            else if (r < 6)
                pending_cmds.push_back(make_cmd(OP_REMOVE, rand_wide(), rand_wide(), rand_wide()));
            else if (r < 9)
                pending_cmds.push_back(make_cmd(OP_CANCEL, $urandom_range(1, 20),
                    base + $urandom_range(0, price_span), rand_wide()));
            else
                pending_cmds.push_back(make_cmd(OP_QUERY, rand_wide(), rand_wide(), rand_wide()));
        end
    endtask

    initial
    begin
        bid_side = 1'b0;
        used = 0;
        for (int i = 0; i < LEVELS; i++) lvl_count[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_cmds.push_back(make_cmd(OP_REMOVE, 32'h0, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CANCEL, 32'h5, 32'h10, 32'h0));
        pending_cmds.push_back(make_cmd(OP_QUERY, 32'h0, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_ADD, 32'h0, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_ADD, 32'h7, 32'h0, 32'h1234));
        pending_cmds.push_back(make_cmd(OP_ADD, 32'h7, 32'h0, 32'h5));
        pending_cmds.push_back(make_cmd(OP_CANCEL, 32'h9, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CANCEL, 32'h7, 32'h0, 32'h0));
        for (int i = 0; i < DEPTH + 1; i++)
            pending_cmds.push_back(make_cmd(OP_ADD, i, 32'h50, 32'hFFFF_FFFF));
        wait_drained();
        write_side(1'b1);
        hold_for_drain = 1'b0;
        pending_cmds.push_back(make_cmd(OP_QUERY, 32'h0, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 32'h0, 32'h0, 32'h0));
        for (int i = 0; i < LEVELS + 2; i++)
            pending_cmds.push_back(make_cmd(OP_ADD, 32'h3, 32'h1000 + i, i));
        for (int i = 0; i < 70; i++)
            pending_cmds.push_back(make_cmd(OP_REMOVE, 32'h0, 32'h0, 32'h0));
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            write_side(phase[0]);
            queue_random(40, phase < 3 ? 8 : 40);
            if (phase == 2) begin
                while (pending_cmds.size() > 20) @(posedge clk);
                drain_done = 1'b0;
                hold_for_drain = 1'b1;
                while (start || busy || expected_views.size() > 0) @(posedge clk);
                drain_done = 1'b1;
                hold_for_drain = 1'b0;
            end
            wait_drained();
        end
        write_side(1'b0);
        queue_random(20, 4);
        wait_drained();

        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/obspt_pkg.sv
hw/rtl/obspt_cell.sv
hw/rtl/order_book_side_price_time.sv
sim/order_book_side_price_time_tb.sv
